>>> rtl/core/button_auto_repeat_assert.svh
// ----------------------------------------------------------------------------
// Button auto-repeat assertion macros
// Shared concurrent-assertion forms, clocked on i_clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_AUTO_REPEAT_ASSERT_SVH
`define BUTTON_AUTO_REPEAT_ASSERT_SVH

// Same-cycle implication.
`define BAR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BAR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/bar_pkg.sv
// ----------------------------------------------------------------------------
// Button auto-repeat package
// Field widths, word codes, register indexes and the lane control bundle.
// ----------------------------------------------------------------------------
package bar_pkg;

    localparam int KIND_W  = 2;
    localparam int MASK_W  = 9;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam int IN_DATA_W  = 48;   // mask + is_down + now_ms, padded to bytes
    localparam int OUT_DATA_W = 16;   // buttons_out, padded to bytes

    localparam logic [KIND_W-1:0] KIND_CHANGE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SYNC   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 1'd1;

    localparam logic [CFG_W-1:0] RESET_DELAY    = 16'd180;
    localparam logic [CFG_W-1:0] RESET_INTERVAL = 16'd90;

    localparam logic [TIME_W-1:0] DISARMED = '0;

    typedef struct packed {
        logic do_change;
        logic do_tick;
        logic is_down;
    } t_lane_ctl;

endpackage

>>> rtl/core/button_auto_repeat.sv
// ----------------------------------------------------------------------------
// Button auto-repeat engine
// Typematic repeat for a row of buttons with held mask, pulse latch and
// per-button repeat deadlines.
// ----------------------------------------------------------------------------
// Usage: each input word is a change (press/release of the buttons in the
// mask), a tick (fire repeat pulses whose deadline has passed) or a sync
// (report held OR pulse, then clear pulses); kind 3 is ignored. Only sync
// words produce an output word. A word can be taken every cycle while no
// stall holds it: it lands in the input register and is applied to the
// state at the clock edge where it retires, and a sync result is on the
// master side from that same edge. The only stall is a sync word meeting
// a full, unread output register. Deadline sums wrap at 32 bits and a sum of
// zero leaves the button disarmed; the time compare is plain unsigned.
// repeat_delay / repeat_interval are to be written through the cfg port by
// the user only while no word is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module button_auto_repeat import bar_pkg::*; #(
    parameter int BUTTONS = 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration writes: 0 repeat_delay, 1 repeat_interval
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    // input words
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [8:0] button_mask, [9] is_down,
                                                 // [41:10] now_ms, [47:42] zero
    input  logic [KIND_W-1:0]     s_axis_tuser,  // [1:0] kind
    // result words
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // [8:0] buttons_out, [15:9] zero
);

    // configuration registers
    logic [CFG_W-1:0] r_delay;
    logic [CFG_W-1:0] r_interval;

    // input register
    logic              r_in_valid;
    logic [KIND_W-1:0] r_kind;
    logic [MASK_W-1:0] r_mask;
    logic              r_down;
    logic [TIME_W-1:0] r_now;

    // engine state
    logic [BUTTONS-1:0] r_held;
    logic [BUTTONS-1:0] r_pulse;
    logic [BUTTONS-1:0] n_held;
    logic [BUTTONS-1:0] n_pulse;

    // output register
    logic              r_out_valid;
    logic [MASK_W-1:0] r_out_buttons;

    logic               out_free;
    logic               fire;
    logic               fire_sync;
    logic               in_take;
    t_lane_ctl          lane_ctl;
    logic [BUTTONS-1:0] sel;
    logic [BUTTONS-1:0] hit;
    logic [BUTTONS-1:0] fresh;
    logic [BUTTONS-1:0] status;
    logic [MASK_W-1:0]  status_out;
    logic [TIME_W-1:0]  arm_delay;
    logic [TIME_W-1:0]  arm_interval;

    // --- handshake --------------------------------------------------------
    // A sync word needs a free output slot; every other word retires at once.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && ((r_kind != KIND_SYNC) || out_free);
    assign fire_sync     = fire && (r_kind == KIND_SYNC);
    assign s_axis_tready = !r_in_valid || fire;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-MASK_W){1'b0}}, r_out_buttons};

    // --- config -----------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay    <= RESET_DELAY;
            r_interval <= RESET_INTERVAL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_REPEAT_DELAY:    r_delay    <= i_cfg_wdata;
                REG_REPEAT_INTERVAL: r_interval <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // --- input register ---------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind <= s_axis_tuser;
            r_mask <= s_axis_tdata[MASK_W-1:0];
            r_down <= s_axis_tdata[MASK_W];
            r_now  <= s_axis_tdata[MASK_W+TIME_W:MASK_W+1];
        end
    end

    // --- mask / status width fitting --------------------------------------
    // Buttons past the mask width are never selected; status bits past
    // BUTTONS read as zero.
    genvar gi;
    generate
        for (gi = 0; gi < BUTTONS; gi++) begin : g_sel
            if (gi < MASK_W) begin : g_in
                assign sel[gi] = r_mask[gi];
            end else begin : g_out
                assign sel[gi] = 1'b0;
            end
        end
        for (gi = 0; gi < MASK_W; gi++) begin : g_status
            if (gi < BUTTONS) begin : g_in
                assign status_out[gi] = status[gi];
            end else begin : g_out
                assign status_out[gi] = 1'b0;
            end
        end
    endgenerate

    // --- lanes ------------------------------------------------------------
    // One shared adder per arm value; every lane compares against r_now.
    assign arm_delay    = r_now + {{(TIME_W-CFG_W){1'b0}}, r_delay};
    assign arm_interval = r_now + {{(TIME_W-CFG_W){1'b0}}, r_interval};

    assign lane_ctl.do_change = fire && (r_kind == KIND_CHANGE);
    assign lane_ctl.do_tick   = fire && (r_kind == KIND_TICK);
    assign lane_ctl.is_down   = r_down;

    generate
        for (gi = 0; gi < BUTTONS; gi++) begin : g_lane
            bar_lane u_lane (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_ctl          (lane_ctl),
                .i_sel          (sel[gi]),
                .i_held         (r_held[gi]),
                .i_now          (r_now),
                .i_arm_delay    (arm_delay),
                .i_arm_interval (arm_interval),
                .o_hit          (hit[gi])
            );
        end
    endgenerate

    // --- held / pulse update ----------------------------------------------
    assign fresh  = sel & ~r_held;     // presses of buttons not yet held
    assign status = r_held | r_pulse;

    always_comb begin
        n_held  = r_held;
        n_pulse = r_pulse;
        if (fire) begin
            case (r_kind)
                KIND_CHANGE: begin
                    if (r_down) begin
                        n_held  = r_held | fresh;
                        n_pulse = r_pulse | fresh;
                    end else begin
                        n_held  = r_held & ~sel;
                    end
                end
                KIND_TICK: begin
                    n_pulse = r_pulse | hit;
                end
                KIND_SYNC: begin
                    n_pulse = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_pulse <= '0;
        end else begin
            r_held  <= n_held;
            r_pulse <= n_pulse;
        end
    end

    // --- output register --------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire_sync) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_sync) begin
            r_out_buttons <= status_out;
        end
    end

    // --- checks -----------------------------------------------------------
`include "button_auto_repeat_assert.svh"

    `BAR_ASSERT_NEXT(a_sync_clears_pulse, fire_sync, r_pulse == '0,
        "pulse latch not cleared after sync")
    `BAR_ASSERT_NOW(a_sync_needs_slot, fire_sync, out_free,
        "sync retired into an occupied output register")
    `BAR_ASSERT_NOW(a_result_from_sync, $rose(r_out_valid), $past(fire_sync),
        "result word without a sync")
    `BAR_ASSERT_NEXT(a_press_pulses, lane_ctl.do_change && r_down && (fresh != '0),
        ((r_held & r_pulse) & $past(fresh)) == $past(fresh),
        "new press did not set held and pulse")

endmodule

>>> rtl/core/bar_lane.sv
// ----------------------------------------------------------------------------
// Button auto-repeat lane
// Repeat deadline of one button: arm, disarm, and expiry check on ticks.
// ----------------------------------------------------------------------------
module bar_lane import bar_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_lane_ctl         i_ctl,
    input  logic              i_sel,          // mask bit of this button
    input  logic              i_held,
    input  logic [TIME_W-1:0] i_now,
    input  logic [TIME_W-1:0] i_arm_delay,    // now + delay
    input  logic [TIME_W-1:0] i_arm_interval, // now + interval
    output logic              o_hit
);

    logic [TIME_W-1:0] r_deadline;
    logic [TIME_W-1:0] n_deadline;

    assign o_hit = i_ctl.do_tick && i_held && (r_deadline != DISARMED)
                   && (i_now >= r_deadline);

    always_comb begin
        n_deadline = r_deadline;
        if (i_ctl.do_change && i_sel) begin
            if (!i_ctl.is_down) begin
                n_deadline = DISARMED;
            end else if (!i_held) begin
                n_deadline = i_arm_delay;
            end
        end else if (o_hit) begin
            n_deadline = i_arm_interval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadline <= DISARMED;
        end else begin
            r_deadline <= n_deadline;
        end
    end

endmodule
